// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under a synchronous reset.
`define ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication under a synchronous reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/tdpt_pkg.sv -----
// Package for the trial-division prime test: default width constant.
// No dependencies.
package tdpt_pkg;

   localparam int VALUE_WIDTH_DEF = 32;

endpackage

// ----- hw/rtl/trial_division_prime_test.sv -----
// Trial-division prime test: one signed request in, one is_prime bit out. A request
// is accepted only while the block is idle. Negative values, zero and one answer in
// the cycle after acceptance. Otherwise every divisor d = 2, 3, ... with d*d <= value
// goes through a bound check in ST_CHECK, then a pass of a shared restoring
// remainder unit in ST_DIVIDE (one bit a cycle); a composite stops at its
// smallest factor. The result is held until taken.
// Depends on tdpt_pkg.
module trial_division_prime_test #(
   parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_is_prime
);

   localparam int CNT_W = $clog2(VALUE_WIDTH);
   localparam int SQ_W  = VALUE_WIDTH + 1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [VALUE_WIDTH-1:0] shift_ff, shift_in;
   logic [VALUE_WIDTH-1:0] div_ff, div_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   prime_ff, prime_in;

   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;
   logic [VALUE_WIDTH-1:0] rem_step;

   // shared remainder step: shift in next dividend bit, subtract divisor if it fits
   assign trial    = {rem_ff, shift_ff[VALUE_WIDTH-1]};
   assign diff     = trial - {1'b0, div_ff};
   assign rem_step = diff[VALUE_WIDTH] ? trial[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = (state_ff == ST_DONE);
   assign rsp_is_prime = prime_ff;

   always_comb begin
      state_in = state_ff;
      value_in = value_ff;
      shift_in = shift_ff;
      div_in   = div_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      prime_in = prime_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               value_in = req_value;
               div_in   = VALUE_WIDTH'(2);
               sq_in    = SQ_W'(4);
               if (req_value[VALUE_WIDTH-1] || (req_value[VALUE_WIDTH-1:1] == '0)) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (sq_ff > {1'b0, value_ff}) begin
               prime_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               rem_in   = '0;
               shift_in = value_ff;
               cnt_in   = CNT_W'(VALUE_WIDTH - 1);
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in   = rem_step;
            shift_in = {shift_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in   = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               if (rem_step == '0) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  div_in   = div_ff + VALUE_WIDTH'(1);
                  sq_in    = sq_ff + {div_ff, 1'b0} + SQ_W'(1);
                  state_in = ST_CHECK;
               end
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      value_ff <= value_in;
      shift_ff <= shift_in;
      div_ff   <= div_in;
      sq_ff    <= sq_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      prime_ff <= prime_in;
   end

endmodule

// ----- hw/rtl/tdpt_checker.sv -----
// Port-level checker for trial_division_prime_test, bound to the top level.
// Depends on assert_macros.svh and tdpt_pkg.
`include "assert_macros.svh"

module tdpt_checker #(
   parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [VALUE_WIDTH-1:0] req_value,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_is_prime
);

   logic req_fire;
   logic small_value;

   assign req_fire    = req_valid && req_ready;
   assign small_value = req_value[VALUE_WIDTH-1] || (req_value[VALUE_WIDTH-1:1] == '0);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_is_prime))
   `ASSERT_NEXT(a_small_fast, clock, reset, req_fire && small_value, rsp_valid && !rsp_is_prime)
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_fire, !req_ready)
   `ASSERT_SAME(a_one_at_a_time, clock, reset, rsp_valid, !req_ready)

endmodule

bind trial_division_prime_test tdpt_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_tdpt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_value    (req_value),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_is_prime (rsp_is_prime)
);

// ----- test/tb_top.sv -----
// Testbench for trial_division_prime_test: checks each is_prime answer against
// a table entry or trial-division predictor, under random valid/ready idling.
// Depends on tdpt_pkg and the trial_division_prime_test RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = tdpt_pkg::VALUE_WIDTH_DEF;
   localparam int RANDOM_REQUESTS = 76;
   localparam int LONG_HOLD_AT = 40;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [W-1:0] value;
      logic         known;
      logic         prime;
   } probe_type;

   typedef struct {
      logic [W-1:0] value;
      bit           prime;
   } prime_answer_type;

   localparam int NUM_PROBES = 24;
   localparam probe_type PROBES [NUM_PROBES] = '{
      '{32'h8000_0000, 1'b1, 1'b0},
      '{32'hFFFF_FFFF, 1'b1, 1'b0},
      '{32'hAAAA_AAAA, 1'b1, 1'b0},
      '{32'h0000_0000, 1'b1, 1'b0},
      '{32'h0000_0001, 1'b1, 1'b0},
      '{32'h0000_0002, 1'b1, 1'b1},
      '{32'h0000_0003, 1'b1, 1'b1},
      '{32'h0000_0004, 1'b1, 1'b0},
      '{32'h7FFF_FFFE, 1'b1, 1'b0},
      '{32'h5555_5555, 1'b0, 1'b0},
      '{32'd5,         1'b0, 1'b0},
      '{32'd9,         1'b0, 1'b0},
      '{32'd25,        1'b0, 1'b0},
      '{32'd49,        1'b0, 1'b0},
      '{32'd97,        1'b0, 1'b0},
      '{32'd121,       1'b0, 1'b0},
      '{32'd169,       1'b0, 1'b0},
      '{32'd211,       1'b0, 1'b0},
      '{32'd255,       1'b0, 1'b0},
      '{32'd256,       1'b0, 1'b0},
      '{32'd257,       1'b0, 1'b0},
      '{32'd63001,     1'b0, 1'b0},
      '{32'd65521,     1'b0, 1'b0},
      '{32'h7FFF_FFFF, 1'b0, 1'b0}
   };

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   logic [W-1:0] req_value;
   logic         rsp_valid;
   logic         rsp_ready;
   logic         rsp_is_prime;

   prime_answer_type pending_answers[$];
   int               fail_count = 0;
   int               requests_sent = 0;
   int               answers_taken = 0;
   int               primes_seen = 0;

   trial_division_prime_test #(.VALUE_WIDTH(W)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_is_prime(rsp_is_prime)
   );

   always #5 clock = ~clock;

   function automatic bit is_prime_value(logic [W-1:0] v);
      longint unsigned n;
      longint unsigned d;
      if (v[W-1]) return 1'b0;
      n = 64'(v);
      if (n < 2) return 1'b0;
      for (d = 2; d <= n / d; d++) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Large positives are kept even or multiples of three so they resolve fast.
   function automatic logic [W-1:0] random_value();
      int unsigned pick;
      logic [W-1:0] v;
      pick = $urandom_range(0, 99);
      v = $urandom;
      if (pick < 20) begin
         v[W-1] = 1'b1;
      end else if (pick < 35) begin
         v[W-1] = 1'b0;
         v[0] = 1'b0;
      end else if (pick < 45) begin
         v = $urandom_range(1, 715827882) * 3;
      end else if (pick < 80) begin
         v = $urandom_range(0, 255);
      end else begin
         v = $urandom_range(0, 65535);
      end
      return v;
   endfunction

   task automatic report_mismatch(string what, logic [W-1:0] v);
      $display("MISMATCH at %0t: %s (value %h)", $realtime, what, v);
      fail_count++;
   endtask

   task automatic send_request(logic [W-1:0] v, logic known, logic prime);
      int gap;
      prime_answer_type entry;
      gap = ((requests_sent / 16) % 3 == 2) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_ready !== 1'b1);
      entry.value = v;
      entry.prime = known ? prime : is_prime_value(v);
      pending_answers.push_back(entry);
      requests_sent++;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < NUM_PROBES; i++) begin
         send_request(PROBES[i].value, PROBES[i].known, PROBES[i].prime);
      end
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i == RANDOM_REQUESTS / 2) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_answers.size() != 0);
         end
         send_request(random_value(), 1'b0, 1'b0);
      end
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("ran %0d directed and %0d random requests, %0d answers taken, %0d prime",
               NUM_PROBES, RANDOM_REQUESTS, answers_taken, primes_seen);
      $display("included sign, zero/one, small primes, prime squares and the 31-bit max");
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      int stall;
      prime_answer_type want;
      rsp_ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (answers_taken == LONG_HOLD_AT) stall = LONG_HOLD_CYCLES;
         else if ((answers_taken / 16) % 3 == 1) stall = 0;
         else stall = $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         answers_taken++;
         if (rsp_is_prime === 1'b1) primes_seen++;
         if (pending_answers.size() == 0) begin
            report_mismatch("answer with no request pending", '0);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_is_prime !== want.prime) begin
               report_mismatch($sformatf("is_prime %b, wanted %b", rsp_is_prime, want.prime),
                               want.value);
            end
         end
      end
   end

   initial begin
      #(100_000_000);
      $display("timeout with %0d answers outstanding", pending_answers.size());
      $display("status: fail");
      $finish;
   end

endmodule
